// ===== hw/rtl/hsbrgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsbrgb_pkg
// Shared constants, sector codes and stage payload types for the
// HSB-to-RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsbrgb_pkg;

  // Fixed point format: unsigned Q1.15, 1.0 = 2^FRAC_BITS
  localparam int FIELD_W   = 16;
  localparam int FRAC_BITS = 15;
  localparam logic [FIELD_W-1:0] FIX_ONE = FIELD_W'(1 << FRAC_BITS);

  // Beat widths on the stream ports
  localparam int IN_DATA_W  = 4 * FIELD_W;
  localparam int OUT_DATA_W = 4 * FIELD_W;

  // Hue sectors, one per sixth of a turn
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // Input beat as a packed struct of named fields
  typedef struct packed {
    logic [FIELD_W-1:0] alpha;
    logic [FIELD_W-1:0] brightness;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] hue;
  } pix_in_t;

  // After stage 1: clamped inputs, sector and hue fraction
  typedef struct packed {
    logic                 gray;
    sector_t              sector;
    logic [FRAC_BITS-1:0] frac;
    logic [FIELD_W-1:0]   sat;
    logic [FIELD_W-1:0]   bright;
    logic [FIELD_W-1:0]   alpha;
  } s1_t;

  // After stage 2: chroma and ramp weight
  typedef struct packed {
    logic               gray;
    sector_t            sector;
    logic [FIELD_W-1:0] chroma;
    logic [FIELD_W-1:0] bright;
    logic [FIELD_W-1:0] weight;
    logic [FIELD_W-1:0] alpha;
  } s2_t;

  // After stage 3: chroma, offset m and intermediate x
  typedef struct packed {
    logic               gray;
    sector_t            sector;
    logic [FIELD_W-1:0] chroma;
    logic [FIELD_W-1:0] mval;
    logic [FIELD_W-1:0] xval;
    logic [FIELD_W-1:0] alpha;
  } s3_t;

  // Result beat as a packed struct of named fields
  typedef struct packed {
    logic [FIELD_W-1:0] alpha;
    logic [FIELD_W-1:0] blue;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] red;
  } pix_out_t;

endpackage

// ===== hw/rtl/hsbrgb_sector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsbrgb_sector
// Stage 1: clamps saturation and brightness, scales hue by six and splits
// it into a sector and a fraction.
// ----------------------------------------------------------------------------
module hsbrgb_sector (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  hsbrgb_pkg::pix_in_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hsbrgb_pkg::s1_t   dn_data
);
  import hsbrgb_pkg::*;

  localparam int SCALED_W = FRAC_BITS + 4;

  logic                vld_r;
  s1_t                 data_r;
  s1_t                 data_nxt;
  logic [SCALED_W-1:0] scaled;

  // Hue times six; below one turn this stays under 6 * 2^FRAC_BITS
  assign scaled = SCALED_W'(up_data.hue) * SCALED_W'(6);

  always_comb begin
    data_nxt.gray   = (up_data.hue >= FIX_ONE);
    data_nxt.sector = sector_t'(scaled[FRAC_BITS+2:FRAC_BITS]);
    data_nxt.frac   = scaled[FRAC_BITS-1:0];
    data_nxt.sat    = (up_data.saturation > FIX_ONE) ? FIX_ONE : up_data.saturation;
    data_nxt.bright = (up_data.brightness > FIX_ONE) ? FIX_ONE : up_data.brightness;
    data_nxt.alpha  = up_data.alpha;
  end

  // Stage register with its own valid; fills whenever it is empty or draining
  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== hw/rtl/hsbrgb_chroma.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsbrgb_chroma
// Stage 2: chroma = brightness * saturation, and the ramp weight (fraction
// in even sectors, one minus fraction in odd sectors).
// ----------------------------------------------------------------------------
module hsbrgb_chroma (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  hsbrgb_pkg::s1_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output hsbrgb_pkg::s2_t dn_data
);
  import hsbrgb_pkg::*;

  localparam int PROD_W = 2 * FIELD_W;

  logic                vld_r;
  s2_t                 data_r;
  s2_t                 data_nxt;
  logic [PROD_W-1:0]   prod;
  logic [FIELD_W-1:0]  frac_ext;

  // Both operands are at most 1.0, so the truncated product fits one field
  assign prod     = PROD_W'(up_data.bright) * PROD_W'(up_data.sat);
  assign frac_ext = FIELD_W'(up_data.frac);

  always_comb begin
    data_nxt.gray   = up_data.gray;
    data_nxt.sector = up_data.sector;
    data_nxt.chroma = prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
    data_nxt.bright = up_data.bright;
    data_nxt.weight = up_data.sector[0] ? (FIX_ONE - frac_ext) : frac_ext;
    data_nxt.alpha  = up_data.alpha;
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== hw/rtl/hsbrgb_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsbrgb_blend
// Stage 3: x = chroma * weight and the gray offset m = brightness - chroma.
// ----------------------------------------------------------------------------
module hsbrgb_blend (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  hsbrgb_pkg::s2_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output hsbrgb_pkg::s3_t dn_data
);
  import hsbrgb_pkg::*;

  localparam int PROD_W = 2 * FIELD_W;

  logic              vld_r;
  s3_t               data_r;
  s3_t               data_nxt;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(up_data.chroma) * PROD_W'(up_data.weight);

  always_comb begin
    data_nxt.gray   = up_data.gray;
    data_nxt.sector = up_data.sector;
    data_nxt.chroma = up_data.chroma;
    data_nxt.mval   = up_data.bright - up_data.chroma;
    data_nxt.xval   = prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
    data_nxt.alpha  = up_data.alpha;
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== hw/rtl/hsbrgb_route.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsbrgb_route
// Stage 4: forms c+m and x+m and steers them to red, green and blue by
// sector; gray beats get m on all three. Holds the output register.
// ----------------------------------------------------------------------------
module hsbrgb_route (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  hsbrgb_pkg::s3_t      up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output hsbrgb_pkg::pix_out_t dn_data
);
  import hsbrgb_pkg::*;

  logic               vld_r;
  pix_out_t           data_r;
  pix_out_t           data_nxt;
  logic [FIELD_W-1:0] hi;
  logic [FIELD_W-1:0] mid;
  logic [FIELD_W-1:0] lo;

  assign hi  = up_data.chroma + up_data.mval;
  assign mid = up_data.xval + up_data.mval;
  assign lo  = up_data.mval;

  // Channel steering
  always_comb begin
    data_nxt.alpha = up_data.alpha;
    if (up_data.gray) begin
      data_nxt.red   = lo;
      data_nxt.green = lo;
      data_nxt.blue  = lo;
    end else begin
      case (up_data.sector)
        SEC_RED_YEL: begin
          data_nxt.red = hi;  data_nxt.green = mid; data_nxt.blue = lo;
        end
        SEC_YEL_GRN: begin
          data_nxt.red = mid; data_nxt.green = hi;  data_nxt.blue = lo;
        end
        SEC_GRN_CYN: begin
          data_nxt.red = lo;  data_nxt.green = hi;  data_nxt.blue = mid;
        end
        SEC_CYN_BLU: begin
          data_nxt.red = lo;  data_nxt.green = mid; data_nxt.blue = hi;
        end
        SEC_BLU_MAG: begin
          data_nxt.red = mid; data_nxt.green = lo;  data_nxt.blue = hi;
        end
        default: begin
          data_nxt.red = hi;  data_nxt.green = lo;  data_nxt.blue = mid;
        end
      endcase
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== hw/rtl/hsb_to_rgb_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsb_to_rgb_converter_unit
// Converts hue/saturation/brightness/alpha beats in Q1.15 to red/green/
// blue/alpha beats in Q1.15 through a four stage pipeline.
//
//   channel | dir | beat contents (low bits first)
//   --------+-----+------------------------------------------------
//   in_     | in  | hue, saturation, brightness, alpha_in (16 b each)
//   out_    | out | red, green, blue, alpha_out (16 b each)
//
// One beat per cycle in and out while out_tready stays high; four register
// stages (sector, chroma, blend, route), which an accepted beat passes in
// that order before it raises out_tvalid.
// Each stage has its own valid bit and fills whenever it is empty or
// draining, so bubbles close up and a stalled output still lets beats
// in until all four stages are full. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module hsb_to_rgb_converter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // hue[15:0], saturation[31:16], brightness[47:32], alpha_in[63:48]
  input  logic [hsbrgb_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // red[15:0], green[31:16], blue[47:32], alpha_out[63:48]
  output logic [hsbrgb_pkg::OUT_DATA_W-1:0] out_tdata
);
  import hsbrgb_pkg::*;

  pix_in_t  in_pix;
  pix_out_t out_pix;
  s1_t      s1_data;
  s2_t      s2_data;
  s3_t      s3_data;
  logic     s1_valid, s1_ready;
  logic     s2_valid, s2_ready;
  logic     s3_valid, s3_ready;

  assign in_pix    = pix_in_t'(in_tdata);
  assign out_tdata = OUT_DATA_W'(out_pix);

  // Stage 1: clamp and hue sector
  hsbrgb_sector u_sector (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_pix),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  // Stage 2: chroma and ramp weight
  hsbrgb_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  // Stage 3: x and m
  hsbrgb_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  // Stage 4: channel steering and output register
  hsbrgb_route u_route (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_data  (s3_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_pix)
  );

endmodule
